### src/ecms_pkg.sv
// ---------------------------------------------------------------------------
// ecms_pkg
// Shared types and constants for the encoder counter with missed-step score.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecms_pkg;

  // operation codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_CHECK  = 2'd1;
  localparam logic [1:0] OP_SET    = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIFFERENTIAL_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT             = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MISSED_STEP_ENABLE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DECAY         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_UP       = 3'd5;
  localparam int unsigned CFG_DATA_W = 16;

  // scaling and score constants
  localparam logic [15:0] SCALE_ONE      = 16'd10000;
  localparam logic [13:0] DIV_TEN_K      = 14'd10000;
  localparam logic signed [24:0] SCORE_LIMIT = 25'sd8192000;
  localparam logic signed [24:0] SCORE_UNIT  = 25'sd256;

  // reciprocal multipliers for division by 625 (after a shift by 4)
  localparam logic [27:0] RECIP_HI   = 28'd219902326;
  localparam int unsigned RECIP_HI_SH = 37;
  localparam logic [29:0] RECIP_LO   = 30'd879609303;
  localparam int unsigned RECIP_LO_SH = 39;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  typedef struct packed {
    logic [1:0]         op;
    logic               chan_a;
    logic               chan_b;
    logic               chan_a_neg;
    logic               chan_b_neg;
    logic signed [31:0] new_position;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] raw_position;
    logic signed [31:0] scaled_position;
    logic signed [23:0] missed_score;
  } out_item_t;

  typedef struct packed {
    logic        differential_mode;
    logic [15:0] scale_factor;
    logic        invert;
    logic        missed_step_enable;
    logic [15:0] step_decay;
    logic        direction_up;
  } cfg_t;

  // snapshot of the counter state after one item
  typedef struct packed {
    logic [31:0]        pos;
    logic signed [23:0] score;
  } rec_t;

endpackage

`default_nettype wire

### src/ecms_front.sv
// ---------------------------------------------------------------------------
// ecms_front
// Decodes each item and updates the position count, levels and score.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecms_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 take,
  input  ecms_pkg::in_item_t  item,
  input  ecms_pkg::cfg_t      cfg,
  output ecms_pkg::rec_t      rec
);
  import ecms_pkg::*;

  logic [31:0]        pos, pos_next;
  logic               level_a_now, level_a_now_next;
  logic               level_b_now, level_b_now_next;
  logic signed [23:0] score, score_next;
  logic signed [31:0] last_pos, last_pos_next;

  logic               accept_levels;
  logic [31:0]        raw;
  logic signed [24:0] score_dec;
  logic               missed;

  // next state for one item
  always_comb begin
    pos_next            = pos;
    level_a_now_next    = level_a_now;
    level_b_now_next    = level_b_now;
    score_next          = score;
    last_pos_next       = last_pos;
    accept_levels = !cfg.differential_mode ||
                    ((item.chan_a ^ item.chan_a_neg) && (item.chan_b ^ item.chan_b_neg));
    raw       = cfg.invert ? (32'd0 - pos) : pos;
    score_dec = (score > 24'sd0) ? ({score[23], score} - $signed({9'd0, cfg.step_decay}))
                                 : {score[23], score};
    missed    = cfg.direction_up ? (last_pos > $signed(raw)) : (last_pos < $signed(raw));
    case (item.op)
      OP_SAMPLE: begin
        if (accept_levels) begin
          level_a_now_next = item.chan_a;
          level_b_now_next = item.chan_b;
        end
        // x1 decode on channel A edges while B is high
        // the held level of A serves as the previous level
        if (level_b_now_next && !level_a_now && level_a_now_next) begin
          pos_next = pos - 32'd1;
        end else if (level_b_now_next && level_a_now && !level_a_now_next) begin
          pos_next = pos + 32'd1;
        end
      end
      OP_CHECK: begin
        if (cfg.missed_step_enable) begin
          if (missed && (score_dec < SCORE_LIMIT)) begin
            score_next = 24'(score_dec + SCORE_UNIT);
          end else begin
            score_next = score_dec[23:0];
          end
          last_pos_next = $signed(raw);
        end
      end
      OP_SET: begin
        pos_next = item.new_position;
      end
      default: begin
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pos            <= '0;
      level_a_now    <= 1'b0;
      level_b_now    <= 1'b0;
      score          <= '0;
      last_pos       <= '0;
    end else if (take) begin
      pos            <= pos_next;
      level_a_now    <= level_a_now_next;
      level_b_now    <= level_b_now_next;
      score          <= score_next;
      last_pos       <= last_pos_next;
    end
  end

  // state after this item goes to the back end
  assign rec.pos   = pos_next;
  assign rec.score = score_next;

endmodule

`default_nettype wire

### src/ecms_fifo.sv
// ---------------------------------------------------------------------------
// ecms_fifo
// Short queue that decouples the front end from the scaling pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecms_fifo #(
  parameter int unsigned DEPTH = ecms_pkg::QUEUE_DEPTH_DEF
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             wr_en,
  input  ecms_pkg::rec_t  wr_data,
  output logic            full,
  input  wire             rd_en,
  output ecms_pkg::rec_t  rd_data,
  output logic            nonempty
);
  import ecms_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  rec_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign nonempty = (count != '0);
  assign rd_data  = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/ecms_back.sv
// ---------------------------------------------------------------------------
// ecms_back
// Scaling pipeline: position times scale over 10000, sign, saturation, bypass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecms_back (
  input  wire                 clk,
  input  wire                 rst,
  input  ecms_pkg::cfg_t      cfg,
  input  wire                 src_valid,
  input  ecms_pkg::rec_t      src_data,
  output logic                src_pop,
  output logic                empty,
  input  wire                 pop,
  output ecms_pkg::out_item_t out_item
);
  import ecms_pkg::*;

  logic advance;
  logic [7:1] v;
  logic out_valid;

  // per stage payload
  logic [31:0]        pos1, pos2, pos3, pos4, pos5, pos6;
  logic signed [23:0] sc1, sc2, sc3, sc4, sc5, sc6;
  logic [31:0]        mag1;
  logic [31:0]        x_hi2, x_hi3, x_hi4;
  logic [31:0]        x_lo2, x_lo3, x_lo4, x_lo5;
  logic [17:0]        q_hi4, q_hi5, q_hi6;
  logic [13:0]        r_hi5;
  logic [32:0]        z6;
  logic [19:0]        q_lo7;
  logic [17:0]        q_hi7;
  logic [31:0]        pos7;
  logic signed [23:0] sc7;

  logic [54:0] prod_hi;
  logic [58:0] prod_lo;
  logic [31:0] q_hi_x;
  logic [34:0] mag;
  logic        neg_res;
  logic [31:0] raw;
  logic [31:0] scaled;

  // whole pipeline moves when the output register frees up
  assign advance = !out_valid || pop;
  assign src_pop = advance && src_valid;
  assign empty   = !out_valid;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v         <= {v[6:1], src_valid};
      out_valid <= v[7];
    end
  end

  // division by 625 of the shifted products
  assign prod_hi = 55'(x_hi3[30:4]) * 55'(RECIP_HI);
  assign prod_lo = 59'(z6[32:4]) * 59'(RECIP_LO);
  assign q_hi_x  = 32'(q_hi4) * 32'(DIV_TEN_K);

  always_ff @(posedge clk) begin
    if (advance) begin
      // magnitude of the count
      pos1 <= src_data.pos;
      sc1  <= src_data.score;
      mag1 <= src_data.pos[31] ? (32'd0 - src_data.pos) : src_data.pos;
      // split product: high and low half of the magnitude times the scale
      pos2  <= pos1;
      sc2   <= sc1;
      x_hi2 <= 32'(mag1[31:16]) * 32'(cfg.scale_factor);
      x_lo2 <= 32'(mag1[15:0]) * 32'(cfg.scale_factor);
      pos3  <= pos2;
      sc3   <= sc2;
      x_hi3 <= x_hi2;
      x_lo3 <= x_lo2;
      // quotient of the high part
      pos4  <= pos3;
      sc4   <= sc3;
      x_hi4 <= x_hi3;
      x_lo4 <= x_lo3;
      q_hi4 <= prod_hi[RECIP_HI_SH +: 18];
      // remainder of the high part
      pos5  <= pos4;
      sc5   <= sc4;
      x_lo5 <= x_lo4;
      q_hi5 <= q_hi4;
      r_hi5 <= 14'(x_hi4 - q_hi_x);
      // remainder carried into the low part
      pos6  <= pos5;
      sc6   <= sc5;
      q_hi6 <= q_hi5;
      z6    <= {3'd0, r_hi5, 16'd0} + {1'b0, x_lo5};
      // quotient of the low part
      pos7  <= pos6;
      sc7   <= sc6;
      q_hi7 <= q_hi6;
      q_lo7 <= prod_lo[RECIP_LO_SH +: 20];
    end
  end

  // sign, saturation and bypass
  always_comb begin
    mag     = {1'b0, q_hi7, 16'd0} + 35'(q_lo7);
    neg_res = pos7[31] ^ cfg.invert;
    raw     = cfg.invert ? (32'd0 - pos7) : pos7;
    if (neg_res) begin
      scaled = (mag > 35'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - mag[31:0]);
    end else begin
      scaled = (mag > 35'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    end
    if ((cfg.scale_factor == 16'd0) || (cfg.scale_factor == SCALE_ONE)) begin
      scaled = raw;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      out_item.raw_position    <= $signed(raw);
      out_item.scaled_position <= $signed(scaled);
      out_item.missed_score    <= sc7;
    end
  end

endmodule

`default_nettype wire

### src/encoder_counter_missed_steps.sv
// A result reaches the output after its item passes the queue, the scaling pipeline and the output register.
// Throughput: one item per cycle while pop keeps up, through the queue and scaling pipeline.
// The input side keeps accepting while results wait, until the internal queue fills.
// Reset: position, levels, score and last checked position clear to zero, registers
// return to their defaults (scale 10000), queue and pipeline come up empty.
// ---------------------------------------------------------------------------
// encoder_counter_missed_steps
// x1 quadrature position counter with missed-step score and scaled output.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module encoder_counter_missed_steps #(
  parameter int unsigned QUEUE_DEPTH = ecms_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 push,
  output logic                                full,
  input  ecms_pkg::in_item_t                  in_item,
  output logic                                empty,
  input  wire                                 pop,
  output ecms_pkg::out_item_t                 out_item,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [ecms_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [ecms_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import ecms_pkg::*;

  cfg_t cfg;
  rec_t front_rec;
  rec_t queue_rec;
  logic take;
  logic queue_nonempty;
  logic queue_pop;

  assign cfg_ready = 1'b1;
  assign take      = push && !full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.differential_mode  <= 1'b0;
      cfg.scale_factor       <= SCALE_ONE;
      cfg.invert             <= 1'b0;
      cfg.missed_step_enable <= 1'b0;
      cfg.step_decay         <= '0;
      cfg.direction_up       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DIFFERENTIAL_MODE:  cfg.differential_mode  <= cfg_data[0];
        CFG_SCALE_FACTOR:       cfg.scale_factor       <= cfg_data;
        CFG_INVERT:             cfg.invert             <= cfg_data[0];
        CFG_MISSED_STEP_ENABLE: cfg.missed_step_enable <= cfg_data[0];
        CFG_STEP_DECAY:         cfg.step_decay         <= cfg_data;
        CFG_DIRECTION_UP:       cfg.direction_up       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // decode and state update
  ecms_front u_front (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .item (in_item),
    .cfg  (cfg),
    .rec  (front_rec)
  );

  // queue between front and back
  ecms_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (take),
    .wr_data  (front_rec),
    .full     (full),
    .rd_en    (queue_pop),
    .rd_data  (queue_rec),
    .nonempty (queue_nonempty)
  );

  // scaling and result register
  ecms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .src_valid (queue_nonempty),
    .src_data  (queue_rec),
    .src_pop   (queue_pop),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

  // score stays within its reachable range
  a_score_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (out_item.missed_score >= -24'sd65535) &&
               (out_item.missed_score <= 24'sd8192256))
    else $error("missed score out of range");

  // a set transfer places the new position into the queue
  a_set_loads: assert property (@(posedge clk) disable iff (rst)
    (take && (in_item.op == OP_SET)) |-> (front_rec.pos == in_item.new_position))
    else $error("set operation did not load position");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("result visible after reset");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Feeds the quadrature position counter with a short directed sequence and
// random encoder walks under several register settings, and compares every
// reported position, scaled position and missed-step score against a local
// model of the counter kept in a scoreboard class.
// ---------------------------------------------------------------------------

module testbench;
  import ecms_pkg::*;

  // op code the block only reports on
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 316;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_GAP = 18;
  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;

  // model of the counter and queue of the readings it predicts
  class position_tracker;
    cfg_t        cfg;
    logic [31:0] count;
    bit          a_now, b_now, a_prev, b_prev;
    int          score;
    int          last_checked;
    out_item_t   expected_readings[$];
    int          mismatches;
    int          readings_checked;

    function new();
      cfg = '0;
      cfg.scale_factor = SCALE_ONE;
      count = '0;
      a_now = 0;
      b_now = 0;
      a_prev = 0;
      b_prev = 0;
      score = 0;
      last_checked = 0;
      mismatches = 0;
      readings_checked = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_DIFFERENTIAL_MODE:  cfg.differential_mode = data[0];
        CFG_SCALE_FACTOR:       cfg.scale_factor = data;
        CFG_INVERT:             cfg.invert = data[0];
        CFG_MISSED_STEP_ENABLE: cfg.missed_step_enable = data[0];
        CFG_STEP_DECAY:         cfg.step_decay = data;
        CFG_DIRECTION_UP:       cfg.direction_up = data[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] shown_raw();
      return cfg.invert ? (32'd0 - count) : count;
    endfunction

    // truncate toward zero, negate, then saturate to 32 bits
    function logic [31:0] shown_scaled();
      longint p, v, s, div;
      if (cfg.scale_factor == 16'd0 || cfg.scale_factor == SCALE_ONE) return shown_raw();
      p = $signed(count);
      s = cfg.scale_factor;
      div = SCALE_ONE;
      v = (p * s) / div;
      if (cfg.invert) v = -v;
      if (v > POS_MAX) v = POS_MAX;
      if (v < POS_MIN) v = POS_MIN;
      return v[31:0];
    endfunction

    function void note_item(in_item_t item);
      out_item_t reading;
      int raw, decay, limit, unit;
      bit missed;
      case (item.op)
        OP_SAMPLE: begin
          a_prev = a_now;
          b_prev = b_now;
          if (!cfg.differential_mode ||
              ((item.chan_a ^ item.chan_a_neg) && (item.chan_b ^ item.chan_b_neg))) begin
            a_now = item.chan_a;
            b_now = item.chan_b;
          end
          // x1 decoding: only A edges while B is high count
          if (b_now && !a_prev && a_now) count = count - 32'd1;
          if (b_now && a_prev && !a_now) count = count + 32'd1;
        end
        OP_CHECK: begin
          if (cfg.missed_step_enable) begin
            raw = $signed(shown_raw());
            decay = cfg.step_decay;
            limit = SCORE_LIMIT;
            unit = SCORE_UNIT;
            if (score > 0) score = score - decay;
            missed = cfg.direction_up ? (last_checked > raw) : (last_checked < raw);
            if (missed && score < limit) score = score + unit;
            last_checked = raw;
          end
        end
        OP_SET: count = item.new_position;
        default: ;
      endcase
      reading.raw_position = shown_raw();
      reading.scaled_position = shown_scaled();
      reading.missed_score = score[23:0];
      expected_readings.push_back(reading);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void check_reading(out_item_t got);
      out_item_t want;
      if (expected_readings.size() == 0) begin
        flag($sformatf("result with no item waiting, raw %0d", got.raw_position));
        return;
      end
      want = expected_readings.pop_front();
      readings_checked++;
      if (got.raw_position !== want.raw_position)
        flag($sformatf("raw_position got %0d want %0d", got.raw_position, want.raw_position));
      if (got.scaled_position !== want.scaled_position)
        flag($sformatf("scaled_position got %0d want %0d",
                       got.scaled_position, want.scaled_position));
      if (got.missed_score !== want.missed_score)
        flag($sformatf("missed_score got %0d want %0d", got.missed_score, want.missed_score));
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  logic                  full;
  in_item_t              in_item = '0;
  logic                  empty;
  logic                  pop = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  position_tracker tracker;
  int gap_pct = 0;
  int qphase = 0;
  int qdir = 1;
  int n_items = 0;
  int n_samples = 0;
  int n_checks = 0;
  int n_sets = 0;
  int n_writes = 0;

  encoder_counter_missed_steps u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: pop with random stall bursts
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst) begin
        pop <= 1'b0;
      end else if (stall > 0 && gap_pct != 0) begin
        pop <= 1'b0;
        stall--;
      end else if ($urandom_range(0, 99) < gap_pct) begin
        pop <= 1'b0;
        stall = $urandom_range(1, MAX_GAP) - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // check each result transfer
  always @(posedge clk) begin
    if (!rst && pop && !empty) tracker.check_reading(out_item);
  end

  function automatic in_item_t make_item(logic [1:0] op, logic a, logic b, logic an,
                                         logic bn, logic [31:0] pos);
    in_item_t item;
    item.op = op;
    item.chan_a = a;
    item.chan_b = b;
    item.chan_a_neg = an;
    item.chan_b_neg = bn;
    item.new_position = pos;
    return item;
  endfunction

  // mostly a legal quadrature walk, with checks, loads, unused ops and noise mixed in
  function automatic in_item_t random_item();
    in_item_t item;
    int roll;
    item.op = OP_SAMPLE;
    item.chan_a = 1'($urandom());
    item.chan_b = 1'($urandom());
    item.chan_a_neg = 1'($urandom());
    item.chan_b_neg = 1'($urandom());
    item.new_position = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 74) begin
      if ($urandom_range(0, 99) < 6) qdir = -qdir;
      if ($urandom_range(0, 99) < 88) qphase = (qphase + qdir + 4) % 4;
      item.chan_a = (qphase == 1 || qphase == 2);
      item.chan_b = (qphase >= 2);
      if ($urandom_range(0, 99) < 90) begin
        item.chan_a_neg = !item.chan_a;
        item.chan_b_neg = !item.chan_b;
      end
    end else if (roll < 78) begin
      // noise sample: levels stay random
    end else if (roll < 92) begin
      item.op = OP_CHECK;
    end else if (roll < 97) begin
      item.op = OP_SET;
      case ($urandom_range(0, 7))
        0: item.new_position = 32'h8000_0000;
        1: item.new_position = 32'h7fff_ffff;
        2: item.new_position = 32'h8000_0001;
        3: item.new_position = 32'h7fff_fffe;
        4: item.new_position = 32'hffff_ffff;
        5: item.new_position = 32'($urandom_range(0, 200)) - 32'd100;
        default: ;
      endcase
    end else begin
      item.op = OP_UNUSED;
    end
    return item;
  endfunction

  // input transfer, then maybe an idle burst
  task automatic send_item(in_item_t item);
    push <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (full);
    tracker.note_item(item);
    n_items++;
    case (item.op)
      OP_SAMPLE: n_samples++;
      OP_CHECK:  n_checks++;
      OP_SET:    n_sets++;
      default: ;
    endcase
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
  endtask

  // register write transfer; valid stays high for the next write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
    n_writes++;
  endtask

  task automatic load_settings(cfg_t c);
    write_reg(CFG_DIFFERENTIAL_MODE, CFG_DATA_W'(c.differential_mode));
    write_reg(CFG_SCALE_FACTOR, c.scale_factor);
    write_reg(CFG_INVERT, CFG_DATA_W'(c.invert));
    write_reg(CFG_MISSED_STEP_ENABLE, CFG_DATA_W'(c.missed_step_enable));
    write_reg(CFG_STEP_DECAY, c.step_decay);
    write_reg(CFG_DIRECTION_UP, CFG_DATA_W'(c.direction_up));
    cfg_valid <= 1'b0;
  endtask

  // wait until every expected result is back and the pipeline is quiet
  task automatic drain();
    push <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // main sequence
  initial begin
    cfg_t settings;
    tracker = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: differential, max scale, inverted, score on, going down
    settings = '{1'b1, 16'd65535, 1'b1, 1'b1, 16'd300, 1'b0};
    load_settings(settings);
    gap_pct = 10;
    send_item(make_item(OP_SET, 1'b0, 1'b0, 1'b0, 1'b0, 32'h8000_0000));
    send_item(make_item(OP_SET, 1'b1, 1'b1, 1'b1, 1'b1, 32'h7fff_ffff));
    send_item(make_item(OP_SET, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0000));
    send_item(make_item(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0));
    send_item(make_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0));
    send_item(make_item(OP_CHECK, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0));
    send_item(make_item(OP_SAMPLE, 1'b0, 1'b1, 1'b1, 1'b0, 32'h0));
    send_item(make_item(OP_SAMPLE, 1'b1, 1'b1, 1'b0, 1'b0, 32'h0));
    // rejected differential sample: A equals its complement
    send_item(make_item(OP_SAMPLE, 1'b0, 1'b1, 1'b0, 1'b0, 32'h0));
    send_item(make_item(OP_CHECK, 1'b1, 1'b0, 1'b1, 1'b0, 32'h0));
    send_item(make_item(OP_CHECK, 1'b0, 1'b1, 1'b0, 1'b1, 32'h0));
    send_item(make_item(OP_UNUSED, 1'b1, 1'b1, 1'b1, 1'b1, 32'hffff_ffff));
    // A edges with B low do not count
    send_item(make_item(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b1, 32'h0));
    send_item(make_item(OP_SAMPLE, 1'b1, 1'b0, 1'b0, 1'b1, 32'h0));
    send_item(make_item(OP_SAMPLE, 1'b0, 1'b0, 1'b1, 1'b1, 32'h0));
    send_item(make_item(OP_SET, 1'b0, 1'b0, 1'b0, 1'b0, 32'hffff_ffff));
    send_item(make_item(OP_CHECK, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0));
    send_item(make_item(OP_SET, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0000_0001));
    send_item(make_item(OP_CHECK, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0));
    send_item(make_item(OP_SAMPLE, 1'b1, 1'b1, 1'b1, 1'b1, 32'h0));
    send_item(make_item(OP_SAMPLE, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0));
    send_item(make_item(OP_SET, 1'b0, 1'b0, 1'b0, 1'b0, 32'h8000_0000));
    send_item(make_item(OP_CHECK, 1'b0, 1'b0, 1'b0, 1'b0, 32'h0));
    drain();

    // random phases under different settings; the last one runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          settings = '{1'b0, 16'd10000, 1'b0, 1'b1, 16'd0, 1'b0};
          gap_pct = 10;
        end
        1: begin
          settings = '{1'b1, 16'd0, 1'b1, 1'b1, 16'd65535, 1'b1};
          gap_pct = 0;
        end
        2: begin
          settings = '{1'b0, 16'd1, 1'b0, 1'b1, 16'd100, 1'b1};
          gap_pct = 15;
        end
        3: begin
          settings = '{1'b1, 16'd65535, 1'b1, 1'b0, 16'd12345, 1'b0};
          gap_pct = 6;
        end
        4: begin
          settings = '{1'($urandom()), 16'($urandom()), 1'($urandom()), 1'b1,
                       16'($urandom_range(0, 600)), 1'($urandom())};
          gap_pct = 12;
        end
        default: begin
          settings = '{1'b0, 16'($urandom_range(10001, 65534)), 1'b1, 1'b1, 16'd1, 1'b0};
          gap_pct = 0;
        end
      endcase
      load_settings(settings);
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(random_item());
      drain();
    end

    $display("Ran %0d items (%0d samples, %0d checks, %0d loads) through %0d register writes",
             n_items, n_samples, n_checks, n_sets, n_writes);
    $display("over %0d register settings; %0d results compared, %0d mismatches",
             PHASES + 1, tracker.readings_checked, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
